// ===== rtl/core/hrar_pkg.sv =====
`timescale 1ns / 1ps
// Package for the HEX record address range scanner.
// Record type codes, status codes, reset values and the staged item type.
// No dependencies.
package hrar_pkg;

	localparam int unsigned TypeW = 8;
	localparam int unsigned AddrW = 16;
	localparam int unsigned LenW  = 8;
	localparam int unsigned ByteW = 8;
	localparam int unsigned StatW = 2;
	localparam int unsigned WordW = 32;

	localparam logic [TypeW-1:0] REC_DATA          = 8'd0;
	localparam logic [TypeW-1:0] REC_EOF           = 8'd1;
	localparam logic [TypeW-1:0] REC_SEGMENT       = 8'd2;
	localparam logic [TypeW-1:0] REC_START_SEGMENT = 8'd3;
	localparam logic [TypeW-1:0] REC_LINEAR        = 8'd4;

	localparam logic [StatW-1:0] ST_OK            = 2'd0;
	localparam logic [StatW-1:0] ST_PREMATURE_EOF = 2'd1;
	localparam logic [StatW-1:0] ST_UNKNOWN_TYPE  = 2'd2;

	localparam logic [WordW-1:0] MIN_RESET = '1;
	localparam logic [WordW-1:0] MAX_RESET = '0;
	localparam logic [WordW-1:0] OFS_RESET = '0;

	// Segment records shift the 16-bit paragraph by four, linear ones by 16.
	localparam int unsigned SegShift = 4;
	localparam int unsigned LinShift = 16;

	typedef struct packed {
		logic [TypeW-1:0] record_type;
		logic [AddrW-1:0] record_address;
		logic [LenW-1:0]  record_length;
		logic [ByteW-1:0] data_high;
		logic [ByteW-1:0] data_low;
		logic             set_last;
	} rec_t;

endpackage

// ===== rtl/core/hrar_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces: decoded HEX records in, scan results out.
// Depends on hrar_pkg for field widths.
interface hrar_rec_if
	import hrar_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [TypeW-1:0] record_type;
	logic [AddrW-1:0] record_address;
	logic [LenW-1:0]  record_length;
	logic [ByteW-1:0] data_high;
	logic [ByteW-1:0] data_low;
	logic             set_last;

	modport source (output valid, record_type, record_address, record_length,
		data_high, data_low, set_last, input ready);
	modport sink (input valid, record_type, record_address, record_length,
		data_high, data_low, set_last, output ready);
endinterface

interface hrar_res_if
	import hrar_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [StatW-1:0] scan_status;
	logic [WordW-1:0] lowest_address;
	logic [WordW-1:0] highest_end;

	modport source (output valid, scan_status, lowest_address, highest_end,
		input ready);
	modport sink (input valid, scan_status, lowest_address, highest_end,
		output ready);
endinterface

// ===== rtl/core/hrar_stage.sv =====
`timescale 1ns / 1ps
// Input register of the scanner: captures one record per cycle while the scan side advances.
// Depends on hrar_pkg and hrar_rec_if.
module hrar_stage
	import hrar_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	hrar_rec_if.sink    rec,
	input  logic        advance,
	output logic        valid_s1,
	output rec_t        item_s1
);

	always_comb begin
		rec.ready = !valid_s1 || advance;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rec.ready) begin
			valid_s1 <= rec.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rec.ready && rec.valid) begin
			item_s1.record_type    <= rec.record_type;
			item_s1.record_address <= rec.record_address;
			item_s1.record_length  <= rec.record_length;
			item_s1.data_high      <= rec.data_high;
			item_s1.data_low       <= rec.data_low;
			item_s1.set_last       <= rec.set_last;
		end
	end

endmodule

// ===== rtl/core/hrar_scan.sv =====
`timescale 1ns / 1ps
// Scan state (offset, min, max, error) and the result register.
// Depends on hrar_pkg and hrar_res_if.
module hrar_scan
	import hrar_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_s1,
	input  rec_t        item_s1,
	output logic        advance,
	hrar_res_if.source  res
);

	logic [WordW-1:0] base_q;
	logic [WordW-1:0] min_q;
	logic [WordW-1:0] max_q;
	logic [StatW-1:0] err_q;
	logic             out_valid_q;

	logic [WordW-1:0] addr;
	logic [WordW-1:0] rec_end;
	logic [WordW-1:0] base_nx;
	logic [WordW-1:0] min_nx;
	logic [WordW-1:0] max_nx;
	logic [StatW-1:0] err_nx;
	logic             go;
	logic             emit;

	// A record that gives no result never waits on the output side.
	assign advance = valid_s1 && (!item_s1.set_last || !out_valid_q || res.ready);
	assign go      = advance;
	assign emit    = go && item_s1.set_last;

	assign addr    = base_q + {{(WordW-AddrW){1'b0}}, item_s1.record_address};
	assign rec_end = addr + {{(WordW-LenW){1'b0}}, item_s1.record_length};

	always_comb begin
		base_nx = base_q;
		min_nx  = min_q;
		max_nx  = max_q;
		err_nx  = err_q;
		if (err_q == ST_OK) begin
			if (addr < min_q) begin
				min_nx = addr;
			end
			case (item_s1.record_type)
				REC_DATA: begin
					if (rec_end > max_q) begin
						max_nx = rec_end;
					end
				end
				REC_EOF: begin
					if (!item_s1.set_last) begin
						err_nx = ST_PREMATURE_EOF;
					end
				end
				REC_SEGMENT: begin
					base_nx = {{(WordW-2*ByteW-SegShift){1'b0}},
						item_s1.data_high, item_s1.data_low, {SegShift{1'b0}}};
				end
				REC_LINEAR: begin
					base_nx = {item_s1.data_high, item_s1.data_low, {LinShift{1'b0}}};
				end
				REC_START_SEGMENT: begin
				end
				default: begin
					err_nx = ST_UNKNOWN_TYPE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= OFS_RESET;
			min_q  <= MIN_RESET;
			max_q  <= MAX_RESET;
			err_q  <= ST_OK;
		end else if (go) begin
			if (item_s1.set_last) begin
				base_q <= OFS_RESET;
				min_q  <= MIN_RESET;
				max_q  <= MAX_RESET;
				err_q  <= ST_OK;
			end else begin
				base_q <= base_nx;
				min_q  <= min_nx;
				max_q  <= max_nx;
				err_q  <= err_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res.scan_status    <= err_nx;
			res.lowest_address <= min_nx;
			res.highest_end    <= max_nx;
		end
	end

	assign res.valid = out_valid_q;

`ifndef SYNTHESIS
	a_reset_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (base_q == OFS_RESET && min_q == MIN_RESET && max_q == MAX_RESET
			&& err_q == ST_OK))
		else $error("scan state not cleared after last record");
	a_frozen_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(go && !item_s1.set_last && err_q != ST_OK) |=>
			($stable(base_q) && $stable(min_q) && $stable(max_q) && $stable(err_q)))
		else $error("state changed after an error");
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(emit))
		else $error("result without a last record");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res.ready) |-> !emit)
		else $error("pending result overwritten");
`endif

endmodule

// ===== rtl/core/hex_record_address_range_top.sv =====
`timescale 1ns / 1ps
// Top level of the HEX record address range scanner.
// Depends on hrar_pkg, hrar_if, hrar_stage and hrar_scan.
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+------------------------------------------------
//  rec     | in  | valid/ready | record_type, record_address, record_length,
//          |     |             | data_high, data_low, set_last
//  res     | out | valid/ready | scan_status, lowest_address, highest_end
//
// One record per cycle while no result is stalled; a record is taken into the input
// register, and its result is then captured in the result register.
// Reset clears the offset, error and valid flags; minimum resets to all ones.
// A stalled result holds only records marked last; other records keep flowing.
module hex_record_address_range_top
	import hrar_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	hrar_rec_if.sink    rec,
	hrar_res_if.source  res
);

	logic valid_s1;
	rec_t item_s1;
	logic advance;

	hrar_stage u_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.rec      (rec),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	hrar_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.advance  (advance),
		.res      (res)
	);

endmodule
